// File: design/rbst_pkg.sv
`timescale 1ns / 1ps
package rbst_pkg;

    localparam int unsigned QW   = 32;          // Q16.16 word
    localparam int unsigned FRAC = 16;          // fraction bits
    localparam int unsigned DW   = QW + 1;      // exact bound - origin
    localparam int unsigned NW   = DW + FRAC;   // scaled numerator / quotient
    localparam int unsigned NLANE = 6;          // three axes, min and max bound

    // register indexes
    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MIN_Z = 3'd2;
    localparam logic [2:0] REG_MAX_X = 3'd3;
    localparam logic [2:0] REG_MAX_Y = 3'd4;
    localparam logic [2:0] REG_MAX_Z = 3'd5;

    localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [QW-1:0] origin_x;
        logic signed [QW-1:0] origin_y;
        logic signed [QW-1:0] origin_z;
        logic signed [QW-1:0] dir_x;
        logic signed [QW-1:0] dir_y;
        logic signed [QW-1:0] dir_z;
    } t_ray_in;

    typedef struct packed {
        logic                 is_hit;
        logic signed [QW-1:0] t_enter;
        logic signed [QW-1:0] t_exit;
        logic signed [QW-1:0] t_hit;
    } t_ray_out;

endpackage

// File: design/ray_box_slab_test.sv
`timescale 1ns / 1ps
// Ray versus axis-aligned box slab test, Q16.16 signed fixed point.
// Input channel: i_valid / o_stall with one ray item on i_ray (origin, direction).
// Output channel: o_valid / i_stall with one result item on o_res per ray.
// An item moves at a clock edge where valid is high and stall is low.
// Box corners sit in six registers written through i_cfg_we / i_cfg_idx /
// i_cfg_data (0..2 lower corner x,y,z, 3..5 upper corner); other indexes are
// ignored. Write them only while no ray is in flight.
// Between the accepting edge and o_valid lie the input register, operand
// prep, 49 restoring divide steps (one quotient bit each, six dividers in
// parallel), saturate, order, merge and the output register, each of them
// registered.
// Throughput is one ray per cycle while the output is not stalled; every stage is a register stage.
// Reset (synchronous, active low) clears the box to zero and drops all
// valid bits; payload is not cleared.
// When the receiver stalls a held result, the whole pipeline freezes and
// o_stall goes high in the same cycle; nothing is lost or repeated.
module ray_box_slab_test
    import rbst_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  t_ray_in       i_ray,
    output logic          o_valid,
    input  logic          i_stall,
    output t_ray_out      o_res,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [QW-1:0] i_cfg_data
);

    localparam int unsigned NS = NW;   // one divide step per quotient bit

    logic signed [QW-1:0] r_box [NLANE];

    logic                 en;
    t_ray_in              r_in;
    logic                 r_in_v;

    // prep / divider pipeline
    logic [NS:0]          r_dv;
    logic [2:0]           r_dz  [NS+1];
    logic [NW-1:0]        r_nq  [NS+1][NLANE];
    logic [QW-1:0]        r_rem [NS+1][NLANE];
    logic [QW-1:0]        r_dm  [NS+1][NLANE];
    logic [NLANE-1:0]     r_neg [NS+1];

    logic                 r_sv;
    logic [2:0]           r_sz;
    logic signed [QW-1:0] r_sq [NLANE];

    logic                 r_ov;
    logic [2:0]           r_used;
    logic signed [QW-1:0] r_near [3];
    logic signed [QW-1:0] r_far  [3];

    logic                 r_mv;
    logic                 r_any;
    logic signed [QW-1:0] r_tin;
    logic signed [QW-1:0] r_tout;

    logic                 r_out_v;
    t_ray_out             r_out;

    assign en      = !(r_out_v && i_stall);
    assign o_stall = !en;
    assign o_valid = r_out_v;
    assign o_res   = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NLANE; k++) r_box[k] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_X: r_box[0] <= i_cfg_data;
                REG_MIN_Y: r_box[1] <= i_cfg_data;
                REG_MIN_Z: r_box[2] <= i_cfg_data;
                REG_MAX_X: r_box[3] <= i_cfg_data;
                REG_MAX_Y: r_box[4] <= i_cfg_data;
                REG_MAX_Z: r_box[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // operand prep: exact difference, magnitudes, quotient sign
    logic signed [QW-1:0] org [3];
    logic signed [QW-1:0] dir [3];
    logic signed [DW-1:0] diff [NLANE];
    logic [DW-1:0]        dmag_n [NLANE];
    logic [QW-1:0]        dmag_d [NLANE];

    assign org[0] = r_in.origin_x;
    assign org[1] = r_in.origin_y;
    assign org[2] = r_in.origin_z;
    assign dir[0] = r_in.dir_x;
    assign dir[1] = r_in.dir_y;
    assign dir[2] = r_in.dir_z;

    always_comb begin
        for (int k = 0; k < NLANE; k++) begin
            diff[k]   = {r_box[k][QW-1], r_box[k]} - {org[k%3][QW-1], org[k%3]};
            dmag_n[k] = diff[k][DW-1] ? DW'(-diff[k]) : DW'(diff[k]);
            dmag_d[k] = dir[k%3][QW-1] ? QW'(-dir[k%3]) : QW'(dir[k%3]);
        end
    end

    // one restoring divide step
    function automatic logic [QW+NW:0] div_step(input logic [QW-1:0] rem,
                                                input logic [NW-1:0] nq,
                                                input logic [QW-1:0] dm);
        logic [QW:0] t;
        logic [QW:0] s;
        logic        b;
        t = {rem, nq[NW-1]};
        s = t - {1'b0, dm};
        b = (t >= {1'b0, dm});
        div_step = {(b ? s[QW-1:0] : t[QW-1:0]), nq[NW-2:0], b, 1'b0};
    endfunction

    logic [QW+NW:0] step [NS][NLANE];
    always_comb begin
        for (int s = 0; s < NS; s++)
            for (int k = 0; k < NLANE; k++)
                step[s][k] = div_step(r_rem[s][k], r_nq[s][k], r_dm[s][k]);
    end

    // input register, prep stage and divider stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_dv   <= '0;
        end else if (en) begin
            r_in_v <= i_valid;
            r_dv   <= {r_dv[NS-1:0], r_in_v};
        end
        if (en) begin
            r_in  <= i_ray;
            r_dz[0] <= {dir[2] == '0, dir[1] == '0, dir[0] == '0};
            for (int k = 0; k < NLANE; k++) begin
                r_nq[0][k]  <= {dmag_n[k], {FRAC{1'b0}}};
                r_rem[0][k] <= '0;
                r_dm[0][k]  <= dmag_d[k];
                r_neg[0][k] <= diff[k][DW-1] ^ dir[k%3][QW-1];
            end
            for (int s = 0; s < NS; s++) begin
                r_dz[s+1]  <= r_dz[s];
                r_neg[s+1] <= r_neg[s];
                for (int k = 0; k < NLANE; k++) begin
                    r_rem[s+1][k] <= step[s][k][QW+NW:NW+1];
                    r_nq[s+1][k]  <= step[s][k][NW:1];
                    r_dm[s+1][k]  <= r_dm[s][k];
                end
            end
        end
    end

    // saturate signed quotients
    localparam logic [NW-1:0] LIM_POS = NW'(33'h0_7FFF_FFFF);
    localparam logic [NW-1:0] LIM_NEG = NW'(33'h0_8000_0000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sv <= 1'b0;
        else if (en)  r_sv <= r_dv[NS];
        if (en) begin
            r_sz <= r_dz[NS];
            for (int k = 0; k < NLANE; k++) begin
                if (r_neg[NS][k])
                    r_sq[k] <= (r_nq[NS][k] > LIM_NEG) ? Q_MIN
                                                       : QW'(-r_nq[NS][k][QW-1:0]);
                else
                    r_sq[k] <= (r_nq[NS][k] > LIM_POS) ? Q_MAX
                                                       : r_nq[NS][k][QW-1:0];
            end
        end
    end

    // order each axis into near and far
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en)  r_ov <= r_sv;
        if (en) begin
            r_used <= ~r_sz;
            for (int a = 0; a < 3; a++) begin
                r_near[a] <= (r_sq[a] > r_sq[a+3]) ? r_sq[a+3] : r_sq[a];
                r_far[a]  <= (r_sq[a] > r_sq[a+3]) ? r_sq[a]   : r_sq[a+3];
            end
        end
    end

    // merge axes: largest entry, smallest exit
    logic signed [QW-1:0] tin_c;
    logic signed [QW-1:0] tout_c;
    always_comb begin
        tin_c  = Q_MIN;
        tout_c = Q_MAX;
        for (int a = 0; a < 3; a++) begin
            if (r_used[a] && r_near[a] > tin_c)  tin_c  = r_near[a];
            if (r_used[a] && r_far[a]  < tout_c) tout_c = r_far[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mv <= 1'b0;
        else if (en)  r_mv <= r_ov;
        if (en) begin
            r_any  <= |r_used;
            r_tin  <= tin_c;
            r_tout <= tout_c;
        end
    end

    // hit decision and output register
    logic hit_c;
    assign hit_c = r_any && (r_tin < r_tout) && (r_tout > 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (en)  r_out_v <= r_mv;
        if (en) begin
            r_out.is_hit  <= hit_c;
            r_out.t_enter <= r_tin;
            r_out.t_exit  <= r_tout;
            r_out.t_hit   <= hit_c ? ((r_tin > 0) ? r_tin : r_tout) : '0;
        end
    end

endmodule

// File: design/rbst_checker.sv
`timescale 1ns / 1ps
module rbst_checker
    import rbst_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_stall,
    input logic     o_valid,
    input logic     i_stall,
    input t_ray_out o_res
);

    // a held result does not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res))
        else $error("result changed while stalled");

    // input stalls only behind a stalled result
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without cause");

    // a hit has entry below exit and a positive distance
    a_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.is_hit |-> o_res.t_enter < o_res.t_exit && o_res.t_hit > 0)
        else $error("inconsistent hit");

    // a miss reports zero distance
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.is_hit |-> o_res.t_hit == '0)
        else $error("miss with nonzero distance");

endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_res   (o_res)
);

// File: test/ray_box_slab_test_test.sv
`timescale 1ns / 1ps
module ray_box_slab_test_test;
    import rbst_pkg::*;

    localparam int LATENCY = 55;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    t_ray_in       i_ray;
    logic          o_valid;
    logic          i_stall;
    t_ray_out      o_res;
    logic          i_cfg_we;
    logic [2:0]    i_cfg_idx;
    logic [QW-1:0] i_cfg_data;

    ray_box_slab_test dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_ray      (i_ray),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // shadow box corners, indexed by register index
    logic signed [QW-1:0] box_reg [6];
    t_ray_out hit_queue [$];
    int       err_count;
    int       hit_seen;
    int       ray_sent;
    int       idle_pct;      // sender and receiver idle percentage
    int       hold_cycles;   // forced receiver hold-off

    // Q16.16 quotient, truncated toward zero, saturated
    function automatic logic signed [63:0] slab_quot(logic signed [QW-1:0] bound,
                                                     logic signed [QW-1:0] org,
                                                     logic signed [QW-1:0] dir);
        logic signed [63:0] num;
        logic signed [63:0] q;
        num = (64'(bound) - 64'(org)) * 64'sd65536;
        q = num / 64'(dir);
        if (q > 64'(Q_MAX)) q = 64'(Q_MAX);
        if (q < 64'(Q_MIN)) q = 64'(Q_MIN);
        return q;
    endfunction

    function automatic t_ray_out slab_hit(t_ray_in r);
        logic signed [QW-1:0] org [3];
        logic signed [QW-1:0] dir [3];
        logic signed [63:0] near_t, far_t, lo, hi, sw;
        logic used;
        t_ray_out res;
        org = '{r.origin_x, r.origin_y, r.origin_z};
        dir = '{r.dir_x, r.dir_y, r.dir_z};
        near_t = 64'(Q_MIN);
        far_t = 64'(Q_MAX);
        used = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (dir[a] != 0) begin
                used = 1'b1;
                lo = slab_quot(box_reg[a], org[a], dir[a]);
                hi = slab_quot(box_reg[a + 3], org[a], dir[a]);
                if (lo > hi) begin
                    sw = lo;
                    lo = hi;
                    hi = sw;
                end
                if (lo > near_t) near_t = lo;
                if (hi < far_t) far_t = hi;
            end
        end
        res.is_hit = used && (near_t < far_t) && (far_t > 0);
        res.t_enter = near_t[QW-1:0];
        res.t_exit = far_t[QW-1:0];
        res.t_hit = !res.is_hit ? '0 : (near_t > 0 ? near_t[QW-1:0] : far_t[QW-1:0]);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [QW-1:0] got, logic [QW-1:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        err_count++;
    endtask

    // result checker and receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (hit_queue.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    t_ray_out want;
                    want = hit_queue.pop_front();
                    hit_seen++;
                    if (o_res.is_hit !== want.is_hit)
                        report_mismatch("is_hit", 32'(o_res.is_hit), 32'(want.is_hit));
                    if (o_res.t_enter !== want.t_enter)
                        report_mismatch("t_enter", o_res.t_enter, want.t_enter);
                    if (o_res.t_exit !== want.t_exit)
                        report_mismatch("t_exit", o_res.t_exit, want.t_exit);
                    if (o_res.t_hit !== want.t_hit)
                        report_mismatch("t_hit", o_res.t_hit, want.t_hit);
                end
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // send one ray, with random idle cycles before it
    task automatic send_ray(t_ray_in r);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ray <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        hit_queue.push_back(slab_hit(r));
        ray_sent++;
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        end_burst();
        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // write enable stays high across back-to-back writes; set_box drops it
    task automatic write_reg(logic [2:0] idx, logic [QW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx <= REG_MAX_Z) box_reg[idx] = val;
    endtask

    task automatic set_box(logic [QW-1:0] mnx, logic [QW-1:0] mny, logic [QW-1:0] mnz,
                           logic [QW-1:0] mxx, logic [QW-1:0] mxy, logic [QW-1:0] mxz);
        write_reg(REG_MIN_X, mnx);
        write_reg(REG_MIN_Y, mny);
        write_reg(REG_MIN_Z, mnz);
        write_reg(REG_MAX_X, mxx);
        write_reg(REG_MAX_Y, mxy);
        write_reg(REG_MAX_Z, mxz);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [QW-1:0] rand_word();
        case ($urandom_range(5))
            0: return $urandom();
            1: return QW'($signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000);
            2: return QW'($signed($urandom_range(0, 32'h0000_2000)) - 32'sh0000_1000);
            3: return Q_MAX - $urandom_range(3);
            4: return Q_MIN + $urandom_range(3);
            default: return '0;
        endcase
    endfunction

    function automatic logic [QW-1:0] rand_dir();
        case ($urandom_range(7))
            0: return '0;
            1: return $urandom();
            2: return $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
            3: return $urandom_range(1) ? Q_MAX : Q_MIN;
            4: return $urandom_range(1) ? 32'h1 : 32'hFFFF_FFFF;
            default: return QW'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
        endcase
    endfunction

    function automatic t_ray_in rand_ray();
        t_ray_in r;
        r.origin_x = rand_word();
        r.origin_y = rand_word();
        r.origin_z = rand_word();
        r.dir_x = rand_dir();
        r.dir_y = rand_dir();
        r.dir_z = rand_dir();
        return r;
    endfunction

    // rays along axes, all-zero direction, extremes, inverted box
    task automatic test_directed();
        t_ray_in r;
        set_box(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        r = '{32'hFFFB_0000, 0, 0, 32'h0001_0000, 0, 0};            send_ray(r);
        r = '{0, 0, 0, 0, 0, 0};                                    send_ray(r);
        r = '{0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000}; send_ray(r);
        r = '{32'h0005_0000, 0, 0, 32'h0001_0000, 0, 0};            send_ray(r);
        r = '{32'h0005_0000, 0, 0, 32'hFFFF_0000, 0, 0};            send_ray(r);
        r = '{Q_MIN, Q_MIN, Q_MIN, 1, 1, 1};                        send_ray(r);
        r = '{Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN};            send_ray(r);
        r = '{Q_MIN, Q_MAX, 0, Q_MAX, 32'hFFFF_FFFF, 0};            send_ray(r);
        r = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};         send_ray(r);
        r = '{0, 32'h0003_0000, 0, 32'h0001_0000, 32'h0001_0000, 0}; send_ray(r);
        drain();
        // saturated box extremes
        set_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
        r = '{0, 0, 0, 1, 0, 0};                                    send_ray(r);
        r = '{0, 0, 0, 1, 1, 1};                                    send_ray(r);
        r = '{Q_MAX, Q_MIN, 0, Q_MIN, Q_MAX, 32'h0001_0000};        send_ray(r);
        drain();
        // ignored register indexes, then an inverted box, min above max
        write_reg(3'd6, 32'hDEAD_BEEF);
        write_reg(3'd7, 32'h1234_5678);
        set_box(32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
                32'hFFFE_0000, 32'hFFFE_0000, 32'hFFFE_0000);
        r = '{32'hFFF0_0000, 0, 0, 32'h0001_0000, 0, 0};            send_ray(r);
        r = '{0, 0, 0, 32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000}; send_ray(r);
        drain();
    endtask

    // random rays against several random and extreme boxes
    task automatic test_random(int n_box, int per_box);
        for (int b = 0; b < n_box; b++) begin
            if (b % 3 == 0)
                set_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
            else
                set_box(rand_word(), rand_word(), rand_word(),
                        rand_word(), rand_word(), rand_word());
            for (int k = 0; k < per_box; k++) send_ray(rand_ray());
            drain();
        end
    endtask

    // receiver holds off long so the pipeline fills and stalls input
    task automatic test_backpressure();
        set_box(32'hFFFC_0000, 32'hFFFC_0000, 32'hFFFC_0000,
                32'h0004_0000, 32'h0004_0000, 32'h0004_0000);
        @(posedge i_clk);
        hold_cycles <= 150;
        for (int k = 0; k < 90; k++) send_ray(rand_ray());
        drain();
    endtask

    // no idling on either side
    task automatic test_full_rate();
        idle_pct = 0;
        set_box(32'h0000_0000, 32'hFFFF_0000, Q_MIN, 32'h0003_0000, 32'h0001_0000, Q_MAX);
        for (int k = 0; k < 150; k++) send_ray(rand_ray());
        drain();
        idle_pct = 26;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ray = '0;
        i_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        err_count = 0;
        hit_seen = 0;
        ray_sent = 0;
        idle_pct = 26;
        hold_cycles = 0;
        for (int i = 0; i < 6; i++) box_reg[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_full_rate();
        test_random(20, 30);

        $display("Sent %0d rays, checked %0d results across %0d box settings,",
                 ray_sent, hit_seen, 25);
        $display("including saturated, inverted and zero-direction cases and stalls.");
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
